// ----- sv/pns3_pkg.sv -----
`timescale 1ns / 1ps

package pns3_pkg;

   // Default widths of the sample and of the filter levels
   localparam int SAMPLE_WIDTH_DEF = 18;
   localparam int STATE_WIDTH_DEF  = 32;

   // Register and field widths
   localparam int ALPHA_W    = 17;
   localparam int WEIGHT_W   = 16;
   localparam int SCALE_W    = 24;
   localparam int STIM_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Fixed-point formats
   localparam int SAMPLE_FRAC = 8;
   localparam int WEIGHT_FRAC = 12;
   localparam int SUM_FRAC    = 16;
   localparam int ALPHA_FRAC  = 16;
   localparam int STIM_SHIFT  = 26;

   // Shared multiplier: second operand width, scale product split
   localparam int MUL_Y_W    = 24;
   localparam int HALF_W     = 20;
   localparam int U_CHECK    = 40;
   localparam int HALF_P_W   = HALF_W + SCALE_W;
   localparam int P_FULL_W   = 64;

   localparam logic [ALPHA_W-1:0] ALPHA_UNITY = ALPHA_W'(1) << ALPHA_FRAC;
   localparam logic [STIM_W-1:0]  STIM_MAX    = '1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA_ONE,
      CSR_ALPHA_TWO,
      CSR_ALPHA_THREE,
      CSR_WEIGHT_ONE,
      CSR_WEIGHT_TWO,
      CSR_WEIGHT_THREE,
      CSR_OUT_SCALE
   } csr_index_type;

   // Microcode fields
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_ALPHA_ONE,
      MUL_ALPHA_TWO,
      MUL_ALPHA_THREE,
      MUL_WEIGHT_ONE,
      MUL_WEIGHT_TWO,
      MUL_WEIGHT_THREE,
      MUL_SCALE_LO,
      MUL_SCALE_HI
   } mul_sel_type;

   typedef enum logic [3:0] {
      POST_NONE,
      POST_LEVEL_ONE,
      POST_LEVEL_TWO,
      POST_LEVEL_THREE,
      POST_SUM_SET,
      POST_SUM_ADD,
      POST_NORM,
      POST_PROD_SET,
      POST_PROD_ADD,
      POST_FINISH
   } post_op_type;

   typedef enum logic {
      JMP_NONE,
      JMP_SKIP
   } jump_type;

   localparam int PROG_LEN = 12;
   localparam int PC_W     = 4;
   localparam logic [PC_W-1:0] PC_FINISH = PC_W'(PROG_LEN - 1);

   typedef struct packed {
      mul_sel_type     mul;
      post_op_type     post;
      jump_type        jump;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   // Sequencer conditions from the datapath
   typedef struct packed {
      logic skip;
      logic hold;
   } seq_cond_type;

   localparam ctrl_word_type CW_NOP = '{MUL_NONE, POST_NONE, JMP_NONE, '0};

   // Microprogram: each word launches at most one multiply and may retire the product of the word before it
   function automatic ctrl_word_type ucode_word(input logic [PC_W-1:0] pc);
      ctrl_word_type cw;
      cw = CW_NOP;
      case (pc)
         4'd0:  cw = '{MUL_ALPHA_ONE,    POST_NONE,        JMP_NONE, '0};
         4'd1:  cw = '{MUL_ALPHA_TWO,    POST_LEVEL_ONE,   JMP_NONE, '0};
         4'd2:  cw = '{MUL_ALPHA_THREE,  POST_LEVEL_TWO,   JMP_NONE, '0};
         4'd3:  cw = '{MUL_WEIGHT_ONE,   POST_LEVEL_THREE, JMP_NONE, '0};
         4'd4:  cw = '{MUL_WEIGHT_TWO,   POST_SUM_SET,     JMP_NONE, '0};
         4'd5:  cw = '{MUL_WEIGHT_THREE, POST_SUM_ADD,     JMP_NONE, '0};
         4'd6:  cw = '{MUL_NONE,         POST_SUM_ADD,     JMP_NONE, '0};
         4'd7:  cw = '{MUL_NONE,         POST_NORM,        JMP_NONE, '0};
         4'd8:  cw = '{MUL_SCALE_LO,     POST_NONE,        JMP_SKIP, PC_FINISH};
         4'd9:  cw = '{MUL_SCALE_HI,     POST_PROD_SET,    JMP_NONE, '0};
         4'd10: cw = '{MUL_NONE,         POST_PROD_ADD,    JMP_NONE, '0};
         4'd11: cw = '{MUL_NONE,         POST_FINISH,      JMP_NONE, '0};
         default: cw = CW_NOP;
      endcase
      return cw;
   endfunction

endpackage

// ----- sv/pns3_seq.sv -----
`timescale 1ns / 1ps

module pns3_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pns3_pkg::seq_cond_type cond,
   output pns3_pkg::ctrl_word_type ctrl,
   output logic                   busy
);
   import pns3_pkg::*;

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ctrl_word_type   cw;

   // Fetch the control word of the current step
   assign cw   = ucode_word(pc_ff);
   assign busy = busy_ff;

   // Issue the word; hold back the final step while the result slot is full
   always_comb begin
      ctrl = CW_NOP;
      if (busy_ff) begin
         ctrl = cw;
         if (cw.post == POST_FINISH && cond.hold) begin
            ctrl.post = POST_NONE;
         end
      end
   end

   // Advance, jump, hold the final step or stop
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (busy_ff) begin
         if (cw.post == POST_FINISH) begin
            if (!cond.hold) begin
               busy_in = 1'b0;
               pc_in   = '0;
            end
         end else if (cw.jump == JMP_SKIP && cond.skip) begin
            pc_in = cw.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= PC_FINISH))
      else $error("step counter left the program");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("start while a transaction is in progress");

   a_hold_keeps_final: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cw.post == POST_FINISH && cond.hold) |=>
         (busy_ff && pc_ff == PC_FINISH))
      else $error("final step left while the result slot was full");

endmodule

// ----- sv/pns_three_branch_stimulation.sv -----
`timescale 1ns / 1ps

// Three-branch nerve stimulation estimate for one gradient axis.
// Request channel (req_valid / req_stall): one signed slew sample and a
// first_sample flag that clears the three filter levels first. Response
// channel (rsp_valid / rsp_stall): stimulation level in percent (Q10.6)
// and a flag set when it was clipped. Configuration (csr_valid / csr_ready,
// always ready): alphas, weights and output scale, written while idle.
// A microcoded sequencer drives one shared multiplier, one product a step:
// 12 steps per transaction, 10 when the scale is zero or the sum is out of
// range. Requests stall while the sequencer is busy; its final step loads
// the response register and ends the transaction together, so a new
// request can be accepted in the cycle in which the response turns valid.
// The finished result sits in an output register, so the next request is
// taken while a stalled response waits; the final step of that next
// transaction holds until the register is free.
// Reset clears the configuration registers and the filter levels and
// empties the response register.
module pns_three_branch_stimulation #(
   parameter int SAMPLE_WIDTH = pns3_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = pns3_pkg::STATE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   input  logic                                   req_first_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pns3_pkg::STIM_W-1:0]            rsp_stim,
   output logic                                   rsp_saturated,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pns3_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pns3_pkg::CSR_DATA_W-1:0]        csr_data
);
   import pns3_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int STW    = STATE_WIDTH;
   localparam int G      = STW - SW - 1;
   localparam int G_POS  = (G > 0) ? G : 0;
   localparam int G_NEG  = (G < 0) ? -G : 0;
   localparam int LM_W   = STW - 1;
   localparam int EXT_W  = SW + G_POS;
   localparam int P_W    = STW + MUL_Y_W;
   localparam int SUM_W  = STW + 16;
   localparam int SH     = SAMPLE_FRAC + G + WEIGHT_FRAC - SUM_FRAC;
   localparam int SH_POS = (SH > 0) ? SH : 0;
   localparam int SH_NEG = (SH < 0) ? -SH : 0;
   localparam int U_RAW_W = SUM_W + 1 + SH_NEG;
   localparam int U_W    = (U_RAW_W > U_CHECK + 1) ? U_RAW_W : U_CHECK + 1;
   localparam logic [U_W-1:0] U_RND = (U_W'(1) << SH_POS) >> 1;
   localparam logic [P_W:0]   STEP_RND = (P_W + 1)'(1) << (ALPHA_FRAC - 1);
   localparam logic [P_FULL_W:0] STIM_RND = (P_FULL_W + 1)'(1) << (STIM_SHIFT - 1);

   // Configuration registers
   logic [ALPHA_W-1:0]  alpha_one_ff, alpha_two_ff, alpha_three_ff;
   logic [WEIGHT_W-1:0] weight_one_ff, weight_two_ff, weight_three_ff;
   logic [SCALE_W-1:0]  scale_ff;

   // Datapath registers
   logic signed [STW-1:0] lvl_one_ff, lvl_two_ff, lvl_three_ff;
   logic signed [STW-1:0] lvl_one_in, lvl_two_in, lvl_three_in;
   logic signed [STW-1:0] xs_ff, xs_in;
   logic [LM_W-1:0]       xm_ff, xm_in;
   logic [P_W-1:0]        prod_ff, prod_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [U_CHECK-1:0]    u_ff, u_in;
   logic                  u_big_ff, u_big_in;
   logic [P_FULL_W-1:0]   p_ff, p_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STIM_W-1:0]     rsp_stim_ff, rsp_stim_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   ctrl_word_type ctrl;
   seq_cond_type  cond;
   logic          busy;
   logic          req_acc;

   // Combinational helpers
   logic                  s_neg;
   logic [SW-1:0]         s_mag;
   logic [EXT_W-1:0]      s_ext;
   logic [LM_W-1:0]       xm_new;
   logic signed [STW-1:0] xs_new;
   logic signed [STW:0]   diff_one, diff_two, diff_three;
   logic [STW-1:0]        dmag_one, dmag_two, dmag_three;
   logic [STW-1:0]        lmag_one, lmag_two, lmag_three;
   logic [ALPHA_W-1:0]    ac_one, ac_two, ac_three;
   logic [STW-1:0]        mx;
   logic [MUL_Y_W-1:0]    my;
   logic [P_W:0]          step_full;
   logic [STW-1:0]        step;
   logic signed [STW:0]   delta;
   logic signed [STW-1:0] upd_lvl;
   logic                  upd_neg;
   logic signed [STW-1:0] lvl_new;
   logic [U_W-1:0]        u_wide;
   logic [P_FULL_W:0]     p_rnd;
   logic [P_FULL_W-STIM_SHIFT:0] stim_full;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = busy;
   assign csr_ready = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_stim      = rsp_stim_ff;
   assign rsp_saturated = rsp_sat_ff;

   // Step sequencer
   assign cond.skip = (scale_ff == '0) || u_big_ff;
   assign cond.hold = rsp_valid_ff && rsp_stall;

   pns3_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_acc),
      .cond  (cond),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   // Write configuration registers; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_one_ff    <= '0;
         alpha_two_ff    <= '0;
         alpha_three_ff  <= '0;
         weight_one_ff   <= '0;
         weight_two_ff   <= '0;
         weight_three_ff <= '0;
         scale_ff        <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALPHA_ONE:    alpha_one_ff    <= csr_data[ALPHA_W-1:0];
            CSR_ALPHA_TWO:    alpha_two_ff    <= csr_data[ALPHA_W-1:0];
            CSR_ALPHA_THREE:  alpha_three_ff  <= csr_data[ALPHA_W-1:0];
            CSR_WEIGHT_ONE:   weight_one_ff   <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_TWO:   weight_two_ff   <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_THREE: weight_three_ff <= csr_data[WEIGHT_W-1:0];
            CSR_OUT_SCALE:    scale_ff        <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Bring the sample magnitude to level format and reapply the sign
   always_comb begin
      s_neg  = req_sample[SW-1];
      s_mag  = s_neg ? (~req_sample + 1'b1) : req_sample;
      s_ext  = EXT_W'(s_mag) << G_POS;
      xm_new = LM_W'(s_ext >> G_NEG);
      xs_new = $signed(STW'(xm_new));
      if (s_neg) begin
         xs_new = -xs_new;
      end
   end

   // Differences and magnitudes for the three branches
   always_comb begin
      diff_one   = {xs_ff[STW-1], xs_ff} - {lvl_one_ff[STW-1], lvl_one_ff};
      diff_two   = $signed({2'b00, xm_ff}) - {lvl_two_ff[STW-1], lvl_two_ff};
      diff_three = {xs_ff[STW-1], xs_ff} - {lvl_three_ff[STW-1], lvl_three_ff};
      dmag_one   = diff_one[STW]   ? STW'(-diff_one)   : STW'(diff_one);
      dmag_two   = diff_two[STW]   ? STW'(-diff_two)   : STW'(diff_two);
      dmag_three = diff_three[STW] ? STW'(-diff_three) : STW'(diff_three);
      lmag_one   = lvl_one_ff[STW-1]   ? STW'(-lvl_one_ff)   : STW'(lvl_one_ff);
      lmag_two   = lvl_two_ff[STW-1]   ? STW'(-lvl_two_ff)   : STW'(lvl_two_ff);
      lmag_three = lvl_three_ff[STW-1] ? STW'(-lvl_three_ff) : STW'(lvl_three_ff);
      // An alpha above one acts as one
      ac_one   = alpha_one_ff[ALPHA_W-1]   ? ALPHA_UNITY : alpha_one_ff;
      ac_two   = alpha_two_ff[ALPHA_W-1]   ? ALPHA_UNITY : alpha_two_ff;
      ac_three = alpha_three_ff[ALPHA_W-1] ? ALPHA_UNITY : alpha_three_ff;
   end

   // Select the operands of the shared multiplier
   always_comb begin
      mx = '0;
      my = '0;
      unique case (ctrl.mul)
         MUL_NONE: begin
            mx = '0;
            my = '0;
         end
         MUL_ALPHA_ONE: begin
            mx = dmag_one;
            my = MUL_Y_W'(ac_one);
         end
         MUL_ALPHA_TWO: begin
            mx = dmag_two;
            my = MUL_Y_W'(ac_two);
         end
         MUL_ALPHA_THREE: begin
            mx = dmag_three;
            my = MUL_Y_W'(ac_three);
         end
         MUL_WEIGHT_ONE: begin
            mx = lmag_one;
            my = MUL_Y_W'(weight_one_ff);
         end
         MUL_WEIGHT_TWO: begin
            mx = lmag_two;
            my = MUL_Y_W'(weight_two_ff);
         end
         MUL_WEIGHT_THREE: begin
            mx = lmag_three;
            my = MUL_Y_W'(weight_three_ff);
         end
         MUL_SCALE_LO: begin
            mx = STW'(u_ff[HALF_W-1:0]);
            my = scale_ff;
         end
         MUL_SCALE_HI: begin
            mx = STW'(u_ff[U_CHECK-1:HALF_W]);
            my = scale_ff;
         end
         default: begin
            mx = '0;
            my = '0;
         end
      endcase
      prod_in = P_W'(mx) * P_W'(my);
   end

   // Filter update: level += round(alpha * diff), sign of the difference
   always_comb begin
      upd_lvl = lvl_one_ff;
      upd_neg = diff_one[STW];
      case (ctrl.post)
         POST_LEVEL_TWO: begin
            upd_lvl = lvl_two_ff;
            upd_neg = diff_two[STW];
         end
         POST_LEVEL_THREE: begin
            upd_lvl = lvl_three_ff;
            upd_neg = diff_three[STW];
         end
         default: begin
            upd_lvl = lvl_one_ff;
            upd_neg = diff_one[STW];
         end
      endcase
      step_full = (P_W + 1)'(prod_ff) + STEP_RND;
      step      = step_full[ALPHA_FRAC +: STW];
      delta     = $signed({1'b0, step});
      if (upd_neg) begin
         delta = -delta;
      end
      lvl_new = STW'({upd_lvl[STW-1], upd_lvl} + delta);
   end

   // Normalize the weighted sum and round the scaled product
   always_comb begin
      u_wide    = ((U_W'(sum_ff) + U_RND) >> SH_POS) << SH_NEG;
      p_rnd     = (P_FULL_W + 1)'(p_ff) + STIM_RND;
      stim_full = p_rnd[P_FULL_W:STIM_SHIFT];
   end

   // Retire the step's post operation and track the response register
   always_comb begin
      lvl_one_in   = lvl_one_ff;
      lvl_two_in   = lvl_two_ff;
      lvl_three_in = lvl_three_ff;
      xs_in        = xs_ff;
      xm_in        = xm_ff;
      sum_in       = sum_ff;
      u_in         = u_ff;
      u_big_in     = u_big_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_stim_in  = rsp_stim_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_acc) begin
         xs_in = xs_new;
         xm_in = xm_new;
         if (req_first_sample) begin
            lvl_one_in   = '0;
            lvl_two_in   = '0;
            lvl_three_in = '0;
         end
      end

      unique case (ctrl.post)
         POST_NONE: ;
         POST_LEVEL_ONE:   lvl_one_in   = lvl_new;
         POST_LEVEL_TWO:   lvl_two_in   = lvl_new;
         POST_LEVEL_THREE: lvl_three_in = lvl_new;
         POST_SUM_SET:     sum_in = prod_ff[SUM_W-1:0];
         POST_SUM_ADD:     sum_in = sum_ff + prod_ff[SUM_W-1:0];
         POST_NORM: begin
            u_in     = u_wide[U_CHECK-1:0];
            u_big_in = |u_wide[U_W-1:U_CHECK];
         end
         POST_PROD_SET: p_in = P_FULL_W'(prod_ff[HALF_P_W-1:0]);
         POST_PROD_ADD: p_in = p_ff + {prod_ff[P_FULL_W-HALF_W-1:0], HALF_W'(0)};
         POST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (scale_ff == '0) begin
               rsp_stim_in = '0;
               rsp_sat_in  = 1'b0;
            end else if (u_big_ff || (stim_full > (P_FULL_W - STIM_SHIFT + 1)'(STIM_MAX))) begin
               rsp_stim_in = STIM_MAX;
               rsp_sat_in  = 1'b1;
            end else begin
               rsp_stim_in = stim_full[STIM_W-1:0];
               rsp_sat_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Hold state and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_one_ff   <= '0;
         lvl_two_ff   <= '0;
         lvl_three_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lvl_one_ff   <= lvl_one_in;
         lvl_two_ff   <= lvl_two_in;
         lvl_three_ff <= lvl_three_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xs_ff       <= xs_in;
      xm_ff       <= xm_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      u_ff        <= u_in;
      u_big_ff    <= u_big_in;
      p_ff        <= p_in;
      rsp_stim_ff <= rsp_stim_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctrl.post == POST_FINISH) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result written over a pending transaction");

   a_sat_at_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_saturated || rsp_stim == STIM_MAX))
      else $error("saturation flag without maximum level");

   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      (ctrl.post == POST_FINISH && scale_ff == '0) |=>
         (rsp_stim == '0 && !rsp_saturated))
      else $error("zero scale gave a nonzero result");

endmodule
